[rtl/core/lrs_pkg.sv]
// ----------------------------------------------------------------------------
// LRU stack reuse distance package
// Shared widths, default sizes and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int SLOT_W        = 3;
    localparam int ADDR_W        = 64;
    localparam int REGION_W      = 8;
    localparam int KIND_W        = 2;
    localparam int DIST_W        = 5;
    localparam int DIST_MAX      = 31;
    localparam int SLOT_EXT_W    = 9;

    localparam int DEF_THREAD_SLOTS = 8;
    localparam int DEF_STACK_DEPTH  = 32;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_MISS      = 2'd0;
    localparam t_kind KIND_READ_HIT  = 2'd1;
    localparam t_kind KIND_WRITE_HIT = 2'd2;
    localparam t_kind KIND_UNUSED    = 2'd3;

endpackage

`default_nettype wire

[rtl/core/lru_stack_reuse_distance.sv]
// ----------------------------------------------------------------------------
// LRU stack reuse distance unit
// Per-thread LRU address stacks with reuse distance reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one access item: thread slot,
//   address, read flag and region tag. Output channel (o_valid / i_stall)
//   gives one result item per access: kind, distance and the region echo.
//   The stack of the slot is scanned top down, one entry per cycle, through
//   a single-port-read stack memory; each compared entry is rewritten one
//   place lower in the same pass, so search and move-to-top share one walk.
//   Up to STACK_DEPTH entries are compared; the walk stops at the first
//   match or after the last filled entry, and a miss that grows the stack
//   passes through a tail state that writes the last carried entry.
//   An out-of-range slot goes from the load state straight to the result.
//   The next item is accepted in the cycle after the result is taken, so
//   a new item is never taken while one is in flight.
//   A stall on the output holds the result and keeps o_stall high.
//   Reset empties every stack through the per-slot fill counts; the stack
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_stack_reuse_distance
    import lrs_pkg::*;
#(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SLOT_W-1:0]   i_thread_slot,
    input  wire logic [ADDR_W-1:0]   i_address,
    input  wire logic                i_is_read,
    input  wire logic [REGION_W-1:0] i_region,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [KIND_W-1:0]        o_kind,
    output logic [DIST_W-1:0]        o_distance,
    output logic [REGION_W-1:0]      o_region_out
);

    localparam int SW        = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = THREAD_SLOTS * STACK_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_SCAN = 5'b00100,
        S_TAIL = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [SW-1:0]         r_slot, n_slot;
    logic                  r_slot_ok, n_slot_ok;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic                  r_rd, n_rd;
    logic [REGION_W-1:0]   r_region, n_region;
    logic [ADDR_W-1:0]     r_carry, n_carry;
    logic [CNT_W-1:0]      r_idx, n_idx;
    t_kind                 r_kind, n_kind;
    logic [DIST_W-1:0]     r_dist, n_dist;

    logic [CNT_W-1:0]      r_fill [THREAD_SLOTS];
    logic [ADDR_W-1:0]     r_mem  [MEM_DEPTH];
    logic [ADDR_W-1:0]     r_rdata;

    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [CNT_W-1:0]      cur_fill;
    logic [CNT_W-1:0]      idx_inc;
    logic [MEM_AW-1:0]     base;
    logic                  mem_we;
    logic [MEM_AW-1:0]     mem_waddr;
    logic                  rd_en;
    logic [MEM_AW-1:0]     rd_addr;
    logic                  fill_we;

    assign slot_ext = SLOT_EXT_W'(i_thread_slot);
    assign cur_fill = r_fill[r_slot];
    assign idx_inc  = r_idx + CNT_W'(1);
    assign base     = MEM_AW'(r_slot * STACK_DEPTH);

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_kind       = r_kind;
    assign o_distance   = r_dist;
    assign o_region_out = r_region;

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_slot_ok = r_slot_ok;
        n_addr    = r_addr;
        n_rd      = r_rd;
        n_region  = r_region;
        n_carry   = r_carry;
        n_idx     = r_idx;
        n_kind    = r_kind;
        n_dist    = r_dist;
        mem_we    = 1'b0;
        mem_waddr = base + MEM_AW'(r_idx);
        rd_en     = 1'b0;
        rd_addr   = base;
        fill_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_slot    = SW'(slot_ext);
                    n_slot_ok = (slot_ext < SLOT_EXT_W'(THREAD_SLOTS));
                    n_addr    = i_address;
                    n_rd      = i_is_read;
                    n_region  = i_region;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                n_carry = r_addr;
                n_idx   = '0;
                n_kind  = KIND_MISS;
                n_dist  = '0;
                if (!r_slot_ok) begin
                    n_state = S_OUT;
                end else if (cur_fill == '0) begin
                    n_state = S_TAIL;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                mem_we = 1'b1;
                if (r_rdata == r_addr) begin
                    n_kind  = r_rd ? KIND_READ_HIT : KIND_WRITE_HIT;
                    n_dist  = r_rd ? ((32'(r_idx) > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                             : DIST_W'(r_idx))
                                   : '0;
                    n_state = S_OUT;
                end else begin
                    n_carry = r_rdata;
                    if (idx_inc < cur_fill) begin
                        rd_en   = 1'b1;
                        rd_addr = base + MEM_AW'(idx_inc);
                        n_idx   = idx_inc;
                    end else if (cur_fill < CNT_W'(STACK_DEPTH)) begin
                        n_idx   = idx_inc;
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_TAIL: begin
                mem_we  = 1'b1;
                fill_we = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_slot    <= n_slot;
        r_slot_ok <= n_slot_ok;
        r_addr    <= n_addr;
        r_rd      <= n_rd;
        r_region  <= n_region;
        r_carry   <= n_carry;
        r_idx     <= n_idx;
        r_kind    <= n_kind;
        r_dist    <= n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < THREAD_SLOTS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (fill_we) begin
            r_fill[r_slot] <= cur_fill + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_carry;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lrs_chk.sv]
// ----------------------------------------------------------------------------
// LRU stack reuse distance checker
// Port-level checks on handshake and result coding, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_chk
    import lrs_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [KIND_W-1:0]   o_kind,
    input wire logic [DIST_W-1:0]   o_distance,
    input wire logic [REGION_W-1:0] o_region_out
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block took an item without going busy");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind != KIND_UNUSED)
        else $error("unused result kind");

    a_dist_only_on_read_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_READ_HIT |-> o_distance == '0)
        else $error("distance set on a result without a read hit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_distance)
                               && $stable(o_region_out))
        else $error("stalled result changed");

endmodule

bind lru_stack_reuse_distance lrs_chk u_lrs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_distance   (o_distance),
    .o_region_out (o_region_out)
);

`default_nettype wire
